// File: rtl/rrnp_pkg.sv
// ----------------------------------------------------------------------------
// rrnp_pkg
// Shared types, constants and lookup functions of the resize request name
// parser.
// ----------------------------------------------------------------------------
package rrnp_pkg;

  localparam int unsigned MaxNameLen  = 256;
  localparam int unsigned MaxFieldLen = 31;
  localparam int unsigned BaseW       = $clog2(MaxNameLen + 1);
  localparam int unsigned SumW        = BaseW + 2;
  localparam int unsigned QDepth      = 4;
  localparam int unsigned QPtrW       = $clog2(QDepth);
  localparam int unsigned QCntW       = $clog2(QDepth + 1);
  localparam int unsigned ValW        = 16;
  localparam int unsigned WeightW     = 17;
  localparam logic [WeightW-1:0] WeightCap = 17'd100000;
  localparam logic [WeightW-1:0] WeightTop = 17'd10000;

  typedef enum logic [4:0] {
    PH_EXT     = 5'b00001,
    PH_QUALITY = 5'b00010,
    PH_HEIGHT  = 5'b00100,
    PH_WIDTH   = 5'b01000,
    PH_BASE    = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    ERR_OK      = 3'd0,
    ERR_EXT     = 3'd1,
    ERR_QUALITY = 3'd2,
    ERR_HEIGHT  = 3'd3,
    ERR_WIDTH   = 3'd4,
    ERR_PATTERN = 3'd5,
    ERR_EMPTY   = 3'd6,
    ERR_LONG    = 3'd7
  } err_e;

  typedef enum logic [1:0] {
    FMT_PNG   = 2'd0,
    FMT_JPG   = 2'd1,
    FMT_WEBP  = 2'd2,
    FMT_OTHER = 2'd3
  } fmt_e;

  // Classified character as it travels from front to back.
  typedef struct packed {
    logic [7:0] upper;
    logic [3:0] digit;
    logic       is_digit;
    logic       is_ws;
    logic       is_plus;
    logic       is_minus;
    logic       is_dot;
    logic       is_us;
    logic       is_x;
    logic       last;
  } item_t;

  // Extension names, reversed since characters arrive last first.
  function automatic logic [7:0] rev_char(input logic [1:0] fmt, input logic [1:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (fmt)
      FMT_PNG: begin
        case (pos)
          2'd0:    c = "G";
          2'd1:    c = "N";
          2'd2:    c = "P";
          default: c = 8'h00;
        endcase
      end
      FMT_JPG: begin
        case (pos)
          2'd0:    c = "G";
          2'd1:    c = "P";
          2'd2:    c = "J";
          default: c = 8'h00;
        endcase
      end
      FMT_WEBP: begin
        case (pos)
          2'd0:    c = "P";
          2'd1:    c = "B";
          2'd2:    c = "E";
          default: c = "W";
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] fmt_len(input logic [1:0] fmt);
    logic [7:0] n;
    case (fmt)
      FMT_WEBP: n = 8'd4;
      default:  n = 8'd3;
    endcase
    return n;
  endfunction

endpackage

// File: rtl/rrnp_front.sv
// ----------------------------------------------------------------------------
// rrnp_front
// Character classifier: tags each incoming character with its class.
// ----------------------------------------------------------------------------
module rrnp_front (
  input  logic [7:0]     ch_i,
  input  logic           last_i,
  output rrnp_pkg::item_t item_o
);
  import rrnp_pkg::*;

  always_comb begin
    item_o          = '0;
    item_o.last     = last_i;
    item_o.is_digit = ch_i inside {["0":"9"]};
    item_o.digit    = 4'(ch_i - 8'h30);
    item_o.is_ws    = ch_i inside {8'h20, [8'h09:8'h0d]};
    item_o.is_plus  = (ch_i == "+");
    item_o.is_minus = (ch_i == "-");
    item_o.is_dot   = (ch_i == ".");
    item_o.is_us    = (ch_i == "_");
    item_o.is_x     = (ch_i == "x");
    item_o.upper    = (ch_i inside {["a":"z"]}) ? ch_i - 8'd32 : ch_i;
  end

endmodule

// File: rtl/rrnp_queue.sv
// ----------------------------------------------------------------------------
// rrnp_queue
// Short FIFO between the classifier and the parser.
// ----------------------------------------------------------------------------
module rrnp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rrnp_pkg::item_t item_i,
  output logic            ready_o,
  output logic            valid_o,
  output rrnp_pkg::item_t item_o,
  input  logic            pop_i
);
  import rrnp_pkg::*;

  item_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;

  assign ready_o = (cnt_q != QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + QCntW'(push_i) - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// File: rtl/rrnp_back.sv
// ----------------------------------------------------------------------------
// rrnp_back
// Parser: walks the phases, reads the numbers, forms and holds the result.
// ----------------------------------------------------------------------------
module rrnp_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [8:0]                prefix_len_i,
  input  logic                      q_valid_i,
  input  rrnp_pkg::item_t           q_item_i,
  output logic                      q_pop_o,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output logic                      res_ok_o,
  output logic [2:0]                res_err_o,
  output logic [15:0]               res_width_o,
  output logic [15:0]               res_height_o,
  output logic [15:0]               res_quality_o,
  output logic [1:0]                res_fmt_o,
  output logic [rrnp_pkg::BaseW-1:0] res_base_o
);
  import rrnp_pkg::*;

  phase_e             phase_q, phase_d;
  logic [7:0]         sect_q, sect_d;
  logic [ValW-1:0]    acc_q, acc_d;
  logic [WeightW-1:0] wgt_q, wgt_d;
  logic [ValW-1:0]    wv_q, wv_d, hv_q, hv_d, qv_q, qv_d;
  logic [2:0]         mask_q, mask_d;
  logic [BaseW-1:0]   base_q, base_d;
  err_e               err_q, err_d;
  logic [ValW-1:0]    fval_q, fval_d;
  logic               fneg_q, fneg_d;
  fmt_e               fmt_q, fmt_d;

  logic               out_valid_q, out_valid_d;
  logic               out_ok_q;
  err_e               out_err_q, out_err_d;
  logic [ValW-1:0]    out_w_q, out_h_q, out_qv_q;
  logic [1:0]         out_fmt_q;
  logic [BaseW-1:0]   out_base_q;

  logic               delim;
  err_e               field_err;
  logic [20:0]        prod;
  logic [21:0]        sum;
  logic [SumW-1:0]    need;
  logic [7:0]         sect_inc;

  assign q_pop_o = q_valid_i && (!q_item_i.last || !out_valid_q || res_ready_i);

  always_comb begin
    phase_d = phase_q;
    sect_d  = sect_q;
    acc_d   = acc_q;
    wgt_d   = wgt_q;
    wv_d    = wv_q;
    hv_d    = hv_q;
    qv_d    = qv_q;
    mask_d  = mask_q;
    base_d  = base_q;
    err_d   = err_q;
    fval_d  = fval_q;
    fneg_d  = fneg_q;
    fmt_d   = fmt_q;
    out_err_d = ERR_OK;

    sect_inc = (sect_q == 8'hff) ? sect_q : sect_q + 8'd1;
    prod = {17'b0, q_item_i.digit} * {4'b0, wgt_q};
    sum  = {6'b0, acc_q} + {1'b0, prod};

    delim = ((phase_q == PH_QUALITY) && q_item_i.is_us) ||
            ((phase_q == PH_HEIGHT)  && q_item_i.is_x)  ||
            ((phase_q == PH_WIDTH)   && q_item_i.is_minus);
    case (phase_q)
      PH_QUALITY: field_err = ERR_QUALITY;
      PH_HEIGHT:  field_err = ERR_HEIGHT;
      default:    field_err = ERR_WIDTH;
    endcase

    if (q_pop_o && (err_q == ERR_OK)) begin
      case (phase_q)
        PH_EXT: begin
          if (q_item_i.is_dot) begin
            if ((sect_q == 8'd0) || (sect_q > 8'(MaxFieldLen))) begin
              err_d = ERR_EXT;
            end else begin
              fmt_d = FMT_OTHER;
              for (int f = 0; f < 3; f++) begin
                if (mask_q[f] && (sect_q == fmt_len(2'(f)))) begin
                  fmt_d = fmt_e'(2'(f));
                end
              end
              phase_d = PH_QUALITY;
              sect_d  = '0;
            end
          end else begin
            for (int f = 0; f < 3; f++) begin
              if ((sect_q >= fmt_len(2'(f))) ||
                  (q_item_i.upper != rev_char(2'(f), sect_q[1:0]))) begin
                mask_d[f] = 1'b0;
              end
            end
            sect_d = sect_inc;
          end
        end
        PH_QUALITY, PH_HEIGHT, PH_WIDTH: begin
          if (delim) begin
            if ((sect_q > 8'(MaxFieldLen)) || fneg_q || (fval_q == '0)) begin
              err_d = field_err;
            end else begin
              case (phase_q)
                PH_QUALITY: begin
                  qv_d    = fval_q;
                  phase_d = PH_HEIGHT;
                end
                PH_HEIGHT: begin
                  hv_d    = fval_q;
                  phase_d = PH_WIDTH;
                end
                default: begin
                  wv_d    = fval_q;
                  phase_d = PH_BASE;
                end
              endcase
              sect_d = '0;
              acc_d  = '0;
              wgt_d  = WeightW'(1);
              fval_d = '0;
              fneg_d = 1'b0;
            end
          end else begin
            sect_d = sect_inc;
            if (q_item_i.is_digit) begin
              acc_d  = (sum > 22'(16'hffff)) ? 16'hffff : sum[ValW-1:0];
              wgt_d  = (wgt_q >= WeightTop) ? WeightCap : WeightW'(wgt_q * 17'd10);
              fval_d = acc_d;
              fneg_d = 1'b0;
            end else begin
              if (q_item_i.is_plus || q_item_i.is_minus) begin
                fval_d = acc_q;
                fneg_d = q_item_i.is_minus && (acc_q != '0);
              end else if (!q_item_i.is_ws) begin
                fval_d = '0;
                fneg_d = 1'b0;
              end
              acc_d = '0;
              wgt_d = WeightW'(1);
            end
          end
        end
        default: begin
          if (base_q < BaseW'(MaxNameLen)) begin
            base_d = base_q + 1'b1;
          end
        end
      endcase
    end

    // Final character: grade the parse using the state it leaves behind.
    need = SumW'(prefix_len_i) + SumW'(base_d) + SumW'(1);
    if (err_d != ERR_OK)                     out_err_d = err_d;
    else if (phase_d != PH_BASE)             out_err_d = ERR_PATTERN;
    else if (base_d == '0)                   out_err_d = ERR_EMPTY;
    else if (need > SumW'(MaxNameLen))       out_err_d = ERR_LONG;
    else                                     out_err_d = ERR_OK;

    out_valid_d = out_valid_q && !res_ready_i;
    if (q_pop_o && q_item_i.last) begin
      out_valid_d = 1'b1;
      phase_d = PH_EXT;
      sect_d  = '0;
      acc_d   = '0;
      wgt_d   = WeightW'(1);
      wv_d    = '0;
      hv_d    = '0;
      qv_d    = '0;
      mask_d  = 3'b111;
      base_d  = '0;
      err_d   = ERR_OK;
      fval_d  = '0;
      fneg_d  = 1'b0;
      fmt_d   = FMT_OTHER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_EXT;
      sect_q      <= '0;
      acc_q       <= '0;
      wgt_q       <= WeightW'(1);
      wv_q        <= '0;
      hv_q        <= '0;
      qv_q        <= '0;
      mask_q      <= 3'b111;
      base_q      <= '0;
      err_q       <= ERR_OK;
      fval_q      <= '0;
      fneg_q      <= 1'b0;
      fmt_q       <= FMT_OTHER;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      sect_q      <= sect_d;
      acc_q       <= acc_d;
      wgt_q       <= wgt_d;
      wv_q        <= wv_d;
      hv_q        <= hv_d;
      qv_q        <= qv_d;
      mask_q      <= mask_d;
      base_q      <= base_d;
      err_q       <= err_d;
      fval_q      <= fval_d;
      fneg_q      <= fneg_d;
      fmt_q       <= fmt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload; fields are zero unless the job is valid.
  // A valid job ends in the base phase, so the stored values are final and
  // the base count still has to add this very character.
  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_item_i.last) begin
      out_ok_q   <= (out_err_d == ERR_OK);
      out_err_q  <= out_err_d;
      out_w_q    <= (out_err_d == ERR_OK) ? wv_q : '0;
      out_h_q    <= (out_err_d == ERR_OK) ? hv_q : '0;
      out_qv_q   <= (out_err_d == ERR_OK) ? qv_q : '0;
      out_fmt_q  <= (out_err_d == ERR_OK) ? fmt_q : '0;
      out_base_q <= (out_err_d == ERR_OK) ? base_q + 1'b1 : '0;
    end
  end

  assign res_valid_o   = out_valid_q;
  assign res_ok_o      = out_ok_q;
  assign res_err_o     = out_err_q;
  assign res_width_o   = out_w_q;
  assign res_height_o  = out_h_q;
  assign res_quality_o = out_qv_q;
  assign res_fmt_o     = out_fmt_q;
  assign res_base_o    = out_base_q;

  a_ok_matches_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_ok_q == (out_err_q == ERR_OK)))
    else $error("valid flag disagrees with error code");

  a_bad_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ok_q) |-> (out_w_q == '0 && out_base_q == '0 && out_fmt_q == '0))
    else $error("rejected result carries payload");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && q_item_i.last) |=> (phase_q == PH_EXT && err_q == ERR_OK && base_q == '0))
    else $error("parser did not restart after final character");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_ready_i) |=> (out_valid_q && $stable(out_err_q) && $stable(out_w_q)))
    else $error("waiting result changed");

endmodule

// File: rtl/resize_request_name_parser.sv
// ----------------------------------------------------------------------------
// resize_request_name_parser
// Reads a request name base-WxH_Q.ext last character first and reports
// width, height, quality, format and base length, or an error code.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake                    payload
//  -------  ---  ---------------------------  -----------------------------
//  s_axis   in   s_axis_tvalid/s_axis_tready  tdata = ch, tlast = is_final
//  m_axis   out  m_axis_tvalid/m_axis_tready  tuser = valid_res, tdata = job
//  cfg      in   cfg_valid_i/cfg_ready_o      cfg_data_i = path_length
//
//  One character per cycle sustained while no result is stalled; the parser makes
//  one update per character, so the per-character state loop sets the rate.
//  A result is registered once its final character leaves the queue.
//  Reset clears the parser, the queue pointers, the output valid flag and path_length.
//  A stalled result holds only the parser when the next final character
//  needs the output register; the four-entry queue keeps input flowing until full.
//  cfg_ready_o is always high; the user writes path_length while idle, unchecked.
//
module resize_request_name_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request characters
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tlast,   // is_final
  // parse results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [2:0] error_code, [18:3] width,
                                      // [34:19] height, [50:35] quality,
                                      // [52:51] format_code, [61:53] base_length
  output logic        m_axis_tuser,   // valid_res
  // path length register
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [8:0]  cfg_data_i
);
  import rrnp_pkg::*;

  logic [8:0]        prefix_len_q;
  item_t             front_item, q_item;
  logic              q_valid, q_pop;
  logic              res_ok;
  logic [2:0]        res_err;
  logic [15:0]       res_w, res_h, res_qv;
  logic [1:0]        res_fmt;
  logic [BaseW-1:0]  res_base;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_len_q <= '0;
    end else if (cfg_valid_i) begin
      prefix_len_q <= cfg_data_i;
    end
  end

  // Front: classify each character as it is taken.
  rrnp_front u_front (
    .ch_i   (s_axis_tdata),
    .last_i (s_axis_tlast),
    .item_o (front_item)
  );

  rrnp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid && s_axis_tready),
    .item_i  (front_item),
    .ready_o (s_axis_tready),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  // Back: phase walk, number reading and result register.
  rrnp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .prefix_len_i  (prefix_len_q),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_ok_o      (res_ok),
    .res_err_o     (res_err),
    .res_width_o   (res_w),
    .res_height_o  (res_h),
    .res_quality_o (res_qv),
    .res_fmt_o     (res_fmt),
    .res_base_o    (res_base)
  );

  assign m_axis_tuser = res_ok;
  assign m_axis_tdata = {2'b00, res_base, res_fmt, res_qv, res_h, res_w, res_err};

endmodule
